// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that holds in the same cycle as its trigger.
`define TWGD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("touch wheel check failed");

// Check a consequence in the cycle after its trigger.
`define TWGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch wheel check failed");

`endif

// ----- hw/rtl/twgd_pkg.sv -----
// Shared types, constants and helper functions of the touch wheel dimmer.
package twgd_pkg;

  localparam int unsigned RawW    = 6;
  localparam int unsigned SectorW = 4;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned StepsW  = 3;
  localparam int unsigned CountW  = 8;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam int unsigned QueueDepth = 2;

  localparam logic [SectorW-1:0] HalfTurn       = SectorW'(8);
  localparam logic [LevelW-1:0]  LevelMax       = LevelW'(100);
  localparam logic [LevelW-1:0]  LevelReset     = LevelW'(60);
  localparam logic [LevelW-1:0]  ButtonStep     = LevelW'(20);
  localparam logic [CountW-1:0]  IdleLimitReset = CountW'(200);
  localparam logic [RawW-1:0]    RotationReset  = RawW'(8);

  typedef enum logic [0:0] {
    REG_IDLE_LIMIT     = 1'b0,
    REG_WHEEL_ROTATION = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_IDLE   = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_WHEEL  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CountW-1:0] idle_limit;
    logic [RawW-1:0]   wheel_rotation;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [SectorW-1:0] sector;
  } cmd_t;

  typedef struct packed {
    logic [LevelW-1:0]  level;
    logic               gesture_valid;
    logic [StepsW-1:0]  gesture_steps;
    logic               gesture_ccw;
    logic               button_press;
    logic [SectorW-1:0] sector;
    logic               sector_valid;
    logic               idle_timeout;
  } result_t;

  // Next multiple of the button step above lv; full brightness wraps to off.
  function automatic logic [LevelW-1:0] button_level(input logic [LevelW-1:0] lv);
    if (lv >= LevelMax) begin
      return '0;
    end else if (lv < ButtonStep) begin
      return ButtonStep;
    end else if (lv < LevelW'(2 * ButtonStep)) begin
      return LevelW'(2 * ButtonStep);
    end else if (lv < LevelW'(3 * ButtonStep)) begin
      return LevelW'(3 * ButtonStep);
    end else if (lv < LevelW'(4 * ButtonStep)) begin
      return LevelW'(4 * ButtonStep);
    end else begin
      return LevelMax;
    end
  endfunction

endpackage

// ----- hw/rtl/twgd_if.sv -----
// Sample and result channel interfaces of the touch wheel dimmer.
interface twgd_sample_if;
  logic       valid;
  logic       ready;
  logic       wheel_touched;
  logic [5:0] wheel_raw;
  logic       button_touched;

  modport source (output valid, output wheel_touched, output wheel_raw,
                  output button_touched, input ready);
  modport sink   (input valid, input wheel_touched, input wheel_raw,
                  input button_touched, output ready);
endinterface

interface twgd_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] level;
  logic       gesture_valid;
  logic [2:0] gesture_steps;
  logic       gesture_ccw;
  logic       button_press;
  logic [3:0] sector;
  logic       sector_valid;
  logic       idle_timeout;

  modport source (output valid, output level, output gesture_valid, output gesture_steps,
                  output gesture_ccw, output button_press, output sector,
                  output sector_valid, output idle_timeout, input ready);
  modport sink   (input valid, input level, input gesture_valid, input gesture_steps,
                  input gesture_ccw, input button_press, input sector,
                  input sector_valid, input idle_timeout, output ready);
endinterface

// ----- hw/rtl/twgd_regs.sv -----
// APB configuration registers: idle limit and wheel rotation.
module twgd_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [twgd_pkg::AddrW-1:0] paddr_i,
  input  logic [twgd_pkg::DataW-1:0] pwdata_i,
  output logic [twgd_pkg::DataW-1:0] prdata_o,
  output logic                       pready_o,
  output twgd_pkg::cfg_t             cfg_o
);
  import twgd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx      = reg_idx_e'(paddr_i[2]);
  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_IDLE_LIMIT:     cfg_d.idle_limit     = pwdata_i[CountW-1:0];
        REG_WHEEL_ROTATION: cfg_d.wheel_rotation = pwdata_i[RawW-1:0];
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IDLE_LIMIT:     prdata_o = DataW'(cfg_q.idle_limit);
      REG_WHEEL_ROTATION: prdata_o = DataW'(cfg_q.wheel_rotation);
      default:            prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_limit     <= IdleLimitReset;
      cfg_q.wheel_rotation <= RotationReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ----- hw/rtl/twgd_front.sv -----
// Front end: take a sample, rotate and quantise the wheel, classify it.
module twgd_front (
  twgd_sample_if.sink                  smp,
  input  logic [twgd_pkg::RawW-1:0]    wheel_rotation_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output twgd_pkg::cmd_t               push_data_o
);
  import twgd_pkg::*;

  logic [RawW-1:0] pos;

  // rotate modulo the raw span, keep the top bits as the sector
  assign pos = smp.wheel_raw - wheel_rotation_i;

  always_comb begin
    push_data_o.sector = pos[RawW-1 -: SectorW];
    if (smp.wheel_touched) begin
      push_data_o.kind = KIND_WHEEL;
    end else if (smp.button_touched) begin
      push_data_o.kind = KIND_BUTTON;
    end else begin
      push_data_o.kind = KIND_IDLE;
    end
  end

  assign push_valid_o = smp.valid;
  assign smp.ready    = push_ready_i;
endmodule

// ----- hw/rtl/twgd_fifo.sv -----
// Short queue of classified samples between front and back end.
module twgd_fifo #(
  parameter int unsigned Depth = twgd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  twgd_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output twgd_pkg::cmd_t pop_data_o
);
  import twgd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end
endmodule

// ----- hw/rtl/twgd_back.sv -----
// Back end: gesture, button and idle state update with a result register.
module twgd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [twgd_pkg::CountW-1:0] idle_limit_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  twgd_pkg::cmd_t              pop_data_i,
  twgd_result_if.source               res
);
  import twgd_pkg::*;

  logic [SectorW-1:0] last_sector_q, last_sector_d;
  logic               last_valid_q, last_valid_d;
  logic [LevelW-1:0]  level_q, level_d;
  logic               gesture_active_q, gesture_active_d;
  logic               button_held_q, button_held_d;
  logic [CountW-1:0]  idle_count_q, idle_count_d;
  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;

  logic               take;
  logic [SectorW-1:0] diff, neg_diff;
  logic               have, ccw, hold, apply;
  logic [StepsW-1:0]  steps;
  logic [StepsW:0]    delta;
  logic [LevelW:0]    level_up;
  logic [CountW-1:0]  count_inc;

  assign take        = pop_valid_i && (!out_valid_q || res.ready);
  assign pop_ready_o = !out_valid_q || res.ready;

  // signed sector step, half a turn is ambiguous and ignored
  assign diff      = pop_data_i.sector - last_sector_q;
  assign neg_diff  = SectorW'(0) - diff;
  assign have      = last_valid_q && (diff != HalfTurn);
  assign ccw       = have && diff[SectorW-1];
  assign steps     = ccw ? neg_diff[StepsW-1:0] : diff[StepsW-1:0];
  assign hold      = have && !gesture_active_q && (steps <= StepsW'(1));
  assign apply     = have && !hold && (steps != '0);
  assign delta     = {steps, 1'b0};  // gain of two
  assign level_up  = {1'b0, level_q} + (LevelW+1)'(delta);
  assign count_inc = idle_count_q + CountW'(1);

  always_comb begin
    last_sector_d    = last_sector_q;
    last_valid_d     = last_valid_q;
    level_d          = level_q;
    gesture_active_d = gesture_active_q;
    button_held_d    = button_held_q;
    idle_count_d     = idle_count_q;
    res_d            = res_q;
    out_valid_d      = out_valid_q && !res.ready;

    if (take) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      unique case (pop_data_i.kind)
        KIND_WHEEL: begin
          button_held_d = 1'b0;
          idle_count_d  = '0;
          last_valid_d  = 1'b1;
          last_sector_d = hold ? last_sector_q : pop_data_i.sector;
          if (apply) begin
            gesture_active_d = 1'b1;
            if (ccw) begin
              level_d = ((LevelW+1)'(delta) > {1'b0, level_q}) ?
                        '0 : level_q - LevelW'(delta);
            end else begin
              level_d = (level_up > {1'b0, LevelMax}) ? LevelMax : level_up[LevelW-1:0];
            end
            res_d.gesture_valid = 1'b1;
            res_d.gesture_steps = steps;
            res_d.gesture_ccw   = ccw;
          end
          res_d.sector       = hold ? last_sector_q : pop_data_i.sector;
          res_d.sector_valid = 1'b1;
        end
        KIND_BUTTON: begin
          if (!button_held_q) begin
            button_held_d      = 1'b1;
            res_d.button_press = 1'b1;
            level_d            = button_level(level_q);
          end
          idle_count_d     = '0;
          last_valid_d     = 1'b0;
          gesture_active_d = 1'b0;
        end
        KIND_IDLE: begin
          button_held_d    = 1'b0;
          last_valid_d     = 1'b0;
          gesture_active_d = 1'b0;
          if (count_inc >= idle_limit_i) begin
            res_d.idle_timeout = 1'b1;
            idle_count_d       = '0;
          end else begin
            idle_count_d = count_inc;
          end
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
      res_d.level = level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sector_q    <= '0;
      last_valid_q     <= 1'b0;
      level_q          <= LevelReset;
      gesture_active_q <= 1'b0;
      button_held_q    <= 1'b0;
      idle_count_q     <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      last_sector_q    <= last_sector_d;
      last_valid_q     <= last_valid_d;
      level_q          <= level_d;
      gesture_active_q <= gesture_active_d;
      button_held_q    <= button_held_d;
      idle_count_q     <= idle_count_d;
      out_valid_q      <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res.valid         = out_valid_q;
  assign res.level         = res_q.level;
  assign res.gesture_valid = res_q.gesture_valid;
  assign res.gesture_steps = res_q.gesture_steps;
  assign res.gesture_ccw   = res_q.gesture_ccw;
  assign res.button_press  = res_q.button_press;
  assign res.sector        = res_q.sector;
  assign res.sector_valid  = res_q.sector_valid;
  assign res.idle_timeout  = res_q.idle_timeout;
endmodule

// ----- hw/rtl/touch_wheel_gesture_dimmer_unit.sv -----
// Top level of the touch wheel gesture dimmer.
//
//  Channel   Direction  Handshake         Carries
//  in_i      sink       valid/ready       wheel_touched, wheel_raw, button_touched
//  out_o     source     valid/ready       level, gesture and button flags, sector, timeout
//  APB       slave      psel/penable      idle_limit at 0x0, wheel_rotation at 0x4
//
//  One sample per cycle while the result channel is not stalled; an accepted request
//  passes through the queue and then the result register of the back end.
//  The queue absorbs up to QUEUE_DEPTH requests while a result waits.
//  Reset (rst_ni low, asynchronous) empties the queue and restores level 60.
//  A stalled result holds the back end; the front stalls only once the queue is full.
module touch_wheel_gesture_dimmer_unit #(
  parameter int unsigned QUEUE_DEPTH = twgd_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [twgd_pkg::AddrW-1:0] paddr_i,
  input  logic [twgd_pkg::DataW-1:0] pwdata_i,
  output logic [twgd_pkg::DataW-1:0] prdata_o,
  output logic                       pready_o,
  twgd_sample_if.sink                in_i,
  twgd_result_if.source              out_o
);
  import twgd_pkg::*;

  cfg_t cfg;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  // Configuration: the user must write it only while no request is in flight; not enforced here.
  twgd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  // Front: rotate, quantise to a sector and decide wheel, button or idle.
  twgd_front u_front (
    .smp              (in_i),
    .wheel_rotation_i (cfg.wheel_rotation),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_data_o      (push_data)
  );

  // Decouple so that a stalled result does not block the sample side at once.
  twgd_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: hysteresis, gesture steps, brightness clamp, button and idle timing.
  twgd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .idle_limit_i (cfg.idle_limit),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .res          (out_o)
  );
endmodule

// ----- hw/rtl/twgd_checker.sv -----
// Port-level checks of the touch wheel dimmer, bound to the top level.
`include "assert_macros.svh"

module twgd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           pready_i,
  twgd_result_if.source res
);
  logic        res_stall;
  logic [10:0] res_view;
  logic        gesture_ok;
  logic        touch_ok;
  logic        level_ok;

  assign res_stall  = res.valid && !res.ready;
  assign res_view   = {res.level, res.sector};
  assign gesture_ok = !(res.valid && res.gesture_valid) ||
                      (res.sector_valid && res.gesture_steps != 3'd0);
  assign touch_ok   = !(res.valid && res.sector_valid) ||
                      (!res.button_press && !res.idle_timeout);
  assign level_ok   = pready_i && (!res.valid || res.level <= 7'd100);

  // hold the level and sector of a stalled result
  `TWGD_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_stall, res.valid && $stable(res_view))
  // a gesture needs a touched wheel and at least one step
  `TWGD_ASSERT(a_gesture_touch, clk_i, rst_ni, gesture_ok)
  // a touched wheel excludes button press and timeout
  `TWGD_ASSERT(a_touch_excl, clk_i, rst_ni, touch_ok)
  // brightness stays within range, and the port is never wait-stated
  `TWGD_ASSERT(a_level_range, clk_i, rst_ni, level_ok)
endmodule

bind touch_wheel_gesture_dimmer_unit twgd_checker u_twgd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .pready_i (pready_o),
  .res      (out_o)
);
